[rtl/core/swc_pkg.sv]
// Sync word correlator package: payload structs, register indexes and
// reset constants shared by the correlator modules. No dependencies.
package swc_pkg;

    localparam int SYNC_LEN = 19;
    localparam int PAT_W    = 2 * SYNC_LEN;
    localparam int HITS_W   = 5;
    localparam int POS_W    = 12;

    localparam logic [POS_W-1:0]  POS_MAX       = 12'd4095;
    localparam logic [HITS_W-1:0] HITS_RESET    = 5'd16;
    localparam logic [PAT_W-1:0]  PATTERN_RESET = 38'd207890313319;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HITS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_PATTERN = 1'd1;

    typedef struct packed {
        logic [1:0] dibit;
        logic       last;
    } swc_in_t;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  position;
        logic [HITS_W-1:0] matched_count;
        logic              too_long;
    } swc_out_t;

endpackage

[rtl/core/swc_match.sv]
// Nineteen-way dibit compare and popcount of a window against the pattern.
// Depends on swc_pkg.
module swc_match (
    input  logic [swc_pkg::PAT_W-1:0]  window,
    input  logic [swc_pkg::PAT_W-1:0]  pattern,
    output logic [swc_pkg::HITS_W-1:0] hits
);
    import swc_pkg::*;

    logic [PAT_W-1:0]    diff;
    logic [SYNC_LEN-1:0] eq;

    assign diff = window ^ pattern;

    always_comb
    begin
        for (int k = 0; k < SYNC_LEN; k++)
        begin
            eq[k] = (diff[2*k +: 2] == 2'b00);
        end
    end

    always_comb
    begin
        hits = '0;
        for (int k = 0; k < SYNC_LEN; k++)
        begin
            hits = hits + HITS_W'(eq[k]);
        end
    end

endmodule

[rtl/core/swc_track.sv]
// Per-sequence state: shift window, dibit count, best window tracking and
// result formation on the last beat. Depends on swc_pkg and swc_match.
module swc_track #(
    parameter int MAX_DIBITS = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  swc_pkg::swc_in_t           item,
    input  logic [swc_pkg::HITS_W-1:0] min_hits,
    input  logic [swc_pkg::PAT_W-1:0]  pattern,
    output swc_pkg::swc_out_t          result
);
    import swc_pkg::*;

    localparam int CW = $clog2(MAX_DIBITS + 1);
    localparam int SW = (CW > POS_W) ? CW : POS_W;

    logic [PAT_W-1:0]  window_reg, window_next, window_shift;
    logic [CW-1:0]     count_reg, count_next;
    logic [HITS_W-1:0] best_count_reg, best_count_next;
    logic [POS_W-1:0]  best_start_reg, best_start_next;
    logic              overflowed_reg, overflowed_next;
    logic [HITS_W-1:0] hits;
    logic [CW-1:0]     count_inc;
    logic [SW-1:0]     start_ext;
    logic              full;

    assign window_shift = {window_reg[PAT_W-3:0], item.dibit};
    assign count_inc    = count_reg + CW'(1);
    assign full         = (count_reg >= CW'(MAX_DIBITS));
    assign start_ext    = SW'(count_inc) - SW'(SYNC_LEN);

    swc_match u_match (
        .window  (window_shift),
        .pattern (pattern),
        .hits    (hits)
    );

    always_comb
    begin
        window_next     = window_reg;
        count_next      = count_reg;
        best_count_next = best_count_reg;
        best_start_next = best_start_reg;
        overflowed_next = overflowed_reg;
        if (full)
        begin
            overflowed_next = 1'b1;
        end
        else
        begin
            window_next = window_shift;
            count_next  = count_inc;
            if (count_inc >= CW'(SYNC_LEN) && hits > best_count_reg)
            begin
                best_count_next = hits;
                best_start_next = (start_ext > SW'(POS_MAX)) ? POS_MAX
                                                             : start_ext[POS_W-1:0];
            end
        end
    end

    always_comb
    begin
        result.found         = (best_count_next != '0) && (best_count_next >= min_hits);
        result.position      = result.found ? best_start_next : '0;
        result.matched_count = best_count_next;
        result.too_long      = overflowed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            count_reg      <= '0;
            best_count_reg <= '0;
            best_start_reg <= '0;
            overflowed_reg <= 1'b0;
        end
        else if (step)
        begin
            if (item.last)
            begin
                // sequence closes: start fresh for the next one
                window_reg     <= '0;
                count_reg      <= '0;
                best_count_reg <= '0;
                best_start_reg <= '0;
                overflowed_reg <= 1'b0;
            end
            else
            begin
                window_reg     <= window_next;
                count_reg      <= count_next;
                best_count_reg <= best_count_next;
                best_start_reg <= best_start_next;
                overflowed_reg <= overflowed_next;
            end
        end
    end

endmodule

[rtl/core/sync_word_correlator.sv]
// Sliding sync word correlator top level: input register, tracker, result
// register and configuration registers. Depends on swc_pkg and swc_track.
// A last beat passes through the input register and then the result register.
// Throughput: one dibit per cycle through the combinational compare and popcount;
// a last beat waits while the result register is full and stalled, stalling input.
// Reset: sequence state and valids clear; min_hits=16, sync_pattern to default.
module sync_word_correlator #(
    parameter int MAX_DIBITS = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  swc_pkg::swc_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output swc_pkg::swc_out_t             out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [swc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swc_pkg::PAT_W-1:0]     cfg_data
);
    import swc_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    swc_in_t           s1_item_reg;
    logic              out_valid_reg, out_valid_next;
    swc_out_t          out_data_reg;
    logic [HITS_W-1:0] min_hits_reg;
    logic [PAT_W-1:0]  pattern_reg;
    swc_out_t          result;
    logic              s1_go;
    logic              in_fire;

    // a last beat needs the result register free (or emptying this cycle)
    assign s1_go   = s1_valid_reg && (!s1_item_reg.last || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_fire  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
    assign out_valid_next = (s1_go && s1_item_reg.last) ? 1'b1
                          : ((out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg);

    swc_track #(
        .MAX_DIBITS (MAX_DIBITS)
    ) u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (s1_go),
        .item     (s1_item_reg),
        .min_hits (min_hits_reg),
        .pattern  (pattern_reg),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            min_hits_reg  <= HITS_RESET;
            pattern_reg   <= PATTERN_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MIN_HITS:     min_hits_reg <= cfg_data[HITS_W-1:0];
                    REG_SYNC_PATTERN: pattern_reg  <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_data;
        end
        if (s1_go && s1_item_reg.last)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_item_reg.last && out_valid_reg && out_stall) |-> in_stall)
        else $error("last beat advanced into a full result register");

    a_found_meets_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.found) |->
        (out_data.matched_count != '0 && out_data.matched_count >= min_hits_reg))
        else $error("found set below threshold");

    a_position_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |-> (out_data.position == '0))
        else $error("position nonzero without a find");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.matched_count <= HITS_W'(SYNC_LEN)))
        else $error("matched count out of range");

endmodule
